### rtl/hgw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hgw_pkg;

  localparam int unsigned ThrW    = 20;
  localparam int unsigned TimeW   = 63;
  localparam int unsigned CntW    = 32;
  localparam int unsigned ScaledW = 40;

  localparam logic [ScaledW-1:0] NsPerMs     = 40'd1000000;
  localparam logic [ThrW-1:0]    SuspResetMs = 20'd500;
  localparam logic [ThrW-1:0]    DeadResetMs = 20'd2000;
  localparam logic [ScaledW-1:0] SuspResetNs = 40'd500000000;
  localparam logic [ScaledW-1:0] DeadResetNs = 40'd2000000000;

  typedef enum logic {
    REG_SUSPECT = 1'b0,
    REG_DEAD    = 1'b1
  } hgw_reg_e;

  typedef enum logic {
    ACT_OBSERVE = 1'b0,
    ACT_TAKE    = 1'b1
  } hgw_action_e;

  typedef enum logic [1:0] {
    CLS_HEALTHY = 2'd0,
    CLS_SUSPECT = 2'd1,
    CLS_DEAD    = 2'd2
  } hgw_class_e;

  typedef struct packed {
    hgw_action_e      action;
    logic [TimeW-1:0] now_time_ns;
    logic [TimeW-1:0] last_beat_time_ns;
  } hgw_in_t;

  typedef struct packed {
    hgw_class_e       health;
    logic             dead_notice;
    logic [TimeW-1:0] largest_gap_ns;
    logic [CntW-1:0]  suspect_entries;
    logic [CntW-1:0]  dead_entries;
  } hgw_out_t;

  typedef struct packed {
    logic [ScaledW-1:0] suspect_ns;
    logic [ScaledW-1:0] dead_ns;
  } hgw_thr_t;

endpackage

`default_nettype wire

### rtl/hgw_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module hgw_cfg (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire hgw_pkg::hgw_reg_e             cfg_idx_i,
  input  wire logic [hgw_pkg::ThrW-1:0]      cfg_wdata_i,
  output hgw_pkg::hgw_thr_t                  thr_o
);

  logic [hgw_pkg::ScaledW-1:0] scaled_d;
  logic [hgw_pkg::ScaledW-1:0] susp_ns_q;
  logic [hgw_pkg::ScaledW-1:0] dead_ns_q;

  // thresholds are kept already scaled to ns
  always_comb begin
    scaled_d = hgw_pkg::ScaledW'(cfg_wdata_i) * hgw_pkg::NsPerMs;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      susp_ns_q <= hgw_pkg::SuspResetNs;
      dead_ns_q <= hgw_pkg::DeadResetNs;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hgw_pkg::REG_SUSPECT: susp_ns_q <= scaled_d;
        hgw_pkg::REG_DEAD:    dead_ns_q <= scaled_d;
      endcase
    end
  end

  assign thr_o.suspect_ns = susp_ns_q;
  assign thr_o.dead_ns    = dead_ns_q;

endmodule

`default_nettype wire

### rtl/hgw_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hgw_in_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hgw_pkg::hgw_in_t  in_data_i,
  input  wire logic              advance_i,
  output logic                   s1_valid_o,
  output hgw_pkg::hgw_in_t       s1_data_o
);

  logic             s1_valid_q, s1_valid_d;
  hgw_pkg::hgw_in_t s1_data_q;
  logic             load;

  assign in_ready_o = !s1_valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (load) begin
      s1_valid_d = 1'b1;
    end else if (advance_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_data_q <= in_data_i;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_data_o  = s1_data_q;

endmodule

`default_nettype wire

### rtl/hgw_eval.sv
`timescale 1ns / 1ps
`default_nettype none

module hgw_eval (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hgw_pkg::hgw_thr_t thr_i,
  input  wire logic              s1_valid_i,
  input  wire hgw_pkg::hgw_in_t  s1_data_i,
  output logic                   advance_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output hgw_pkg::hgw_out_t      out_data_o
);

  localparam int unsigned TimeW = hgw_pkg::TimeW;
  localparam int unsigned CntW  = hgw_pkg::CntW;

  logic                out_valid_q, out_valid_d;
  hgw_pkg::hgw_class_e class_q, class_d, class_new;
  logic [TimeW-1:0]    max_q, max_d;
  logic [CntW-1:0]     susp_cnt_q, susp_cnt_d;
  logic [CntW-1:0]     dead_cnt_q, dead_cnt_d;
  logic                armed_q, armed_d;
  logic                notice_q, notice_d;
  logic [TimeW:0]      diff;
  logic [TimeW-1:0]    gap;

  assign advance_o = s1_valid_i && (!out_valid_q || out_ready_i);

  // gap clamps at zero when the beat lies in the future
  always_comb begin
    diff = {1'b0, s1_data_i.now_time_ns} - {1'b0, s1_data_i.last_beat_time_ns};
    gap  = diff[TimeW] ? '0 : diff[TimeW-1:0];
    if (gap >= TimeW'(thr_i.dead_ns)) begin
      class_new = hgw_pkg::CLS_DEAD;
    end else if (gap >= TimeW'(thr_i.suspect_ns)) begin
      class_new = hgw_pkg::CLS_SUSPECT;
    end else begin
      class_new = hgw_pkg::CLS_HEALTHY;
    end
  end

  always_comb begin
    class_d    = class_q;
    max_d      = max_q;
    susp_cnt_d = susp_cnt_q;
    dead_cnt_d = dead_cnt_q;
    armed_d    = armed_q;
    notice_d   = 1'b0;
    if (s1_data_i.action == hgw_pkg::ACT_TAKE) begin
      notice_d = armed_q;
      armed_d  = 1'b0;
    end else if (s1_data_i.last_beat_time_ns == '0) begin
      class_d = hgw_pkg::CLS_HEALTHY;
    end else begin
      class_d = class_new;
      if (gap > max_q) begin
        max_d = gap;
      end
      if (class_new != class_q) begin
        case (class_new)
          hgw_pkg::CLS_SUSPECT: begin
            if (susp_cnt_q != '1) begin
              susp_cnt_d = susp_cnt_q + CntW'(1);
            end
          end
          hgw_pkg::CLS_DEAD: begin
            if (dead_cnt_q != '1) begin
              dead_cnt_d = dead_cnt_q + CntW'(1);
            end
            armed_d = 1'b1;
          end
          default: begin
            armed_d = 1'b0;
          end
        endcase
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state registers double as the result word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      class_q     <= hgw_pkg::CLS_HEALTHY;
      max_q       <= '0;
      susp_cnt_q  <= '0;
      dead_cnt_q  <= '0;
      armed_q     <= 1'b0;
      notice_q    <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance_o) begin
        class_q    <= class_d;
        max_q      <= max_d;
        susp_cnt_q <= susp_cnt_d;
        dead_cnt_q <= dead_cnt_d;
        armed_q    <= armed_d;
        notice_q   <= notice_d;
      end
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_data_o.health          = class_q;
  assign out_data_o.dead_notice     = notice_q;
  assign out_data_o.largest_gap_ns  = max_q;
  assign out_data_o.suspect_entries = susp_cnt_q;
  assign out_data_o.dead_entries    = dead_cnt_q;

  a_armed_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    armed_q |-> dead_cnt_q != '0)
    else $error("notice armed with no dead entry counted");

  a_max_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q >= $past(max_q))
    else $error("largest gap decreased");

  a_cnt_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    susp_cnt_q >= $past(susp_cnt_q) && dead_cnt_q >= $past(dead_cnt_q))
    else $error("entry counter decreased");

  a_hold_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance_o |=> $stable(class_q) && $stable(armed_q) && $stable(notice_q))
    else $error("state changed without a word moving");

endmodule

`default_nettype wire

### rtl/heartbeat_gap_watchdog_core.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  | handshake                    | payload
// ---------+------------------------------+-------------------------
// in       | in_valid_i / in_ready_o      | in_data_i  (hgw_in_t)
// out      | out_valid_o / out_ready_i    | out_data_o (hgw_out_t)
// cfg      | cfg_we_i, cfg_idx_i          | cfg_wdata_i (20 bits)
//
// One word per cycle sustained while out_ready_i stays high; results are registered.
// Input register feeds one subtract/compare stage whose state registers are the result.
// Thresholds are scaled to ns at write time, so cfg writes take effect the next cycle.
// Reset clears valid and watchdog state, restores threshold defaults (500 ms, 2000 ms).
// A stalled result holds; the input register still takes one more word.

module heartbeat_gap_watchdog_core (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire hgw_pkg::hgw_in_t         in_data_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output hgw_pkg::hgw_out_t             out_data_o,
  input  wire logic                     cfg_we_i,
  input  wire hgw_pkg::hgw_reg_e        cfg_idx_i,
  input  wire logic [hgw_pkg::ThrW-1:0] cfg_wdata_i
);

  hgw_pkg::hgw_thr_t thr;
  hgw_pkg::hgw_in_t  s1_data;
  logic              s1_valid;
  logic              advance;

  hgw_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .thr_o       (thr)
  );

  hgw_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .advance_i  (advance),
    .s1_valid_o (s1_valid),
    .s1_data_o  (s1_data)
  );

  hgw_eval u_eval (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .thr_i       (thr),
    .s1_valid_i  (s1_valid),
    .s1_data_i   (s1_data),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

### test/tb_heartbeat_gap_watchdog_core.sv
`timescale 1ns / 1ps

module tb_heartbeat_gap_watchdog_core;

  localparam int unsigned TimeW       = hgw_pkg::TimeW;
  localparam int unsigned ThrW        = hgw_pkg::ThrW;
  localparam int unsigned CntW        = hgw_pkg::CntW;
  localparam int unsigned LimitCycles = 200000;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned PhaseWords  = 155;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned HoldCycles  = 60;
  localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};
  localparam longint unsigned NsPerMsL = 64'd1000000;

  typedef struct {
    hgw_pkg::hgw_in_t  word;
    bit                typed;
    hgw_pkg::hgw_out_t result;
  } stim_row_t;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  hgw_pkg::hgw_in_t  in_word   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  hgw_pkg::hgw_out_t out_word;
  logic              cfg_we    = 1'b0;
  hgw_pkg::hgw_reg_e cfg_idx   = hgw_pkg::REG_SUSPECT;
  logic [ThrW-1:0]   cfg_wdata = '0;

  // watchdog state as predicted
  hgw_pkg::hgw_class_e cur_class    = hgw_pkg::CLS_HEALTHY;
  logic [TimeW-1:0]    widest_gap   = '0;
  logic [CntW-1:0]     suspect_cnt  = '0;
  logic [CntW-1:0]     dead_cnt     = '0;
  logic                notice_armed = 1'b0;
  logic [ThrW-1:0]     susp_limit_ms = hgw_pkg::SuspResetMs;
  logic [ThrW-1:0]     dead_ms      = hgw_pkg::DeadResetMs;

  hgw_pkg::hgw_out_t pending_results[$];
  stim_row_t         directed_rows[$];
  hgw_pkg::hgw_out_t want;
  logic [ThrW-1:0]   phase_suspect[NumPhases];
  logic [ThrW-1:0]   phase_dead[NumPhases];

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  int unsigned hold_left    = 0;
  bit          hold_request = 1'b0;
  bit          hold_done    = 1'b0;
  int          errors       = 0;
  int          results_seen = 0;
  int          words_sent   = 0;
  int          cycles       = 0;

  heartbeat_gap_watchdog_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_word),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_word),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [TimeW-1:0] rand_time();
    return TimeW'({$urandom, $urandom});
  endfunction

  function automatic logic [TimeW-1:0] ms_to_ns(logic [ThrW-1:0] ms);
    return TimeW'(NsPerMsL * 64'(ms));
  endfunction

  function automatic hgw_pkg::hgw_out_t watchdog_step(hgw_pkg::hgw_in_t w);
    hgw_pkg::hgw_out_t   r;
    logic [TimeW-1:0]    gap;
    hgw_pkg::hgw_class_e cls;
    logic                notice;
    notice = 1'b0;
    if (w.action == hgw_pkg::ACT_TAKE) begin
      notice = notice_armed;
      notice_armed = 1'b0;
    end else if (w.last_beat_time_ns == '0) begin
      cur_class = hgw_pkg::CLS_HEALTHY;
    end else begin
      gap = (w.now_time_ns > w.last_beat_time_ns) ?
            w.now_time_ns - w.last_beat_time_ns : '0;
      if (gap > widest_gap) widest_gap = gap;
      if (gap >= ms_to_ns(dead_ms)) cls = hgw_pkg::CLS_DEAD;
      else if (gap >= ms_to_ns(susp_limit_ms)) cls = hgw_pkg::CLS_SUSPECT;
      else cls = hgw_pkg::CLS_HEALTHY;
      if (cls != cur_class) begin
        case (cls)
          hgw_pkg::CLS_SUSPECT: begin
            if (suspect_cnt != '1) suspect_cnt = suspect_cnt + 1'b1;
          end
          hgw_pkg::CLS_DEAD: begin
            if (dead_cnt != '1) dead_cnt = dead_cnt + 1'b1;
            notice_armed = 1'b1;
          end
          default: begin
            notice_armed = 1'b0;
          end
        endcase
      end
      cur_class = cls;
    end
    r.health          = cur_class;
    r.dead_notice     = notice;
    r.largest_gap_ns  = widest_gap;
    r.suspect_entries = suspect_cnt;
    r.dead_entries    = dead_cnt;
    return r;
  endfunction

  function automatic hgw_pkg::hgw_in_t make_word();
    hgw_pkg::hgw_in_t w;
    logic [TimeW-1:0] gap;
    logic [TimeW-1:0] thr;
    logic [TimeW-1:0] tmp;
    int unsigned      pick;
    w.action = hgw_pkg::ACT_OBSERVE;
    w.now_time_ns = rand_time();
    w.last_beat_time_ns = ($urandom_range(2) == 0) ? TimeW'($urandom_range(1, 1000)) :
                          rand_time();
    pick = $urandom_range(99);
    if (pick < 12) begin
      w.action = hgw_pkg::ACT_TAKE;
    end else if (pick < 18) begin
      w.last_beat_time_ns = '0;
    end else if (pick < 24) begin
      // beat stamped after now
      if (w.now_time_ns > w.last_beat_time_ns) begin
        tmp = w.now_time_ns;
        w.now_time_ns = w.last_beat_time_ns;
        w.last_beat_time_ns = tmp;
      end
    end else begin
      thr = $urandom_range(1) ? ms_to_ns(susp_limit_ms) : ms_to_ns(dead_ms);
      case ($urandom_range(3))
        0: gap = thr + TimeW'($urandom_range(2)) - 1'b1;
        1: gap = rand_time() % (thr + thr + 2'd2);
        2: gap = TimeW'($urandom);
        default: gap = rand_time();
      endcase
      if (gap > TimeMax - w.last_beat_time_ns) w.last_beat_time_ns = TimeMax - gap;
      w.now_time_ns = w.last_beat_time_ns + gap;
    end
    return w;
  endfunction

  function automatic void add_row(hgw_pkg::hgw_action_e a, logic [TimeW-1:0] now_ns,
                                  logic [TimeW-1:0] last_ns, bit typed,
                                  hgw_pkg::hgw_class_e h, logic n, logic [TimeW-1:0] g,
                                  logic [CntW-1:0] s, logic [CntW-1:0] d);
    stim_row_t row;
    row.word   = '{action: a, now_time_ns: now_ns, last_beat_time_ns: last_ns};
    row.typed  = typed;
    row.result = '{health: h, dead_notice: n, largest_gap_ns: g,
                   suspect_entries: s, dead_entries: d};
    directed_rows.push_back(row);
  endfunction

  task automatic offer_word(hgw_pkg::hgw_in_t w, bit typed, hgw_pkg::hgw_out_t typed_res);
    hgw_pkg::hgw_out_t res;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk_i); while (!in_ready);
    res = watchdog_step(w);
    pending_results.push_back(typed ? typed_res : res);
    words_sent++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_thresholds(logic [ThrW-1:0] s_ms, logic [ThrW-1:0] d_ms);
    cfg_we    <= 1'b1;
    cfg_idx   <= hgw_pkg::REG_SUSPECT;
    cfg_wdata <= s_ms;
    @(posedge clk_i);
    cfg_idx   <= hgw_pkg::REG_DEAD;
    cfg_wdata <= d_ms;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    @(posedge clk_i);
    susp_limit_ms = s_ms;
    dead_ms       = d_ms;
  endtask

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned exp_v);
    errors++;
    $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, exp_v);
  endtask

  // receiver: random ready, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result word", 0, 0);
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_word.health != want.health)
          report_mismatch("health", out_word.health, want.health);
        if (out_word.dead_notice != want.dead_notice)
          report_mismatch("dead_notice", out_word.dead_notice, want.dead_notice);
        if (out_word.largest_gap_ns != want.largest_gap_ns)
          report_mismatch("largest_gap_ns", out_word.largest_gap_ns, want.largest_gap_ns);
        if (out_word.suspect_entries != want.suspect_entries)
          report_mismatch("suspect_entries", out_word.suspect_entries,
                          want.suspect_entries);
        if (out_word.dead_entries != want.dead_entries)
          report_mismatch("dead_entries", out_word.dead_entries, want.dead_entries);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    // defaults: suspect at 500 ms, dead at 2000 ms
    add_row(hgw_pkg::ACT_TAKE, '0, '0, 1'b1, hgw_pkg::CLS_HEALTHY, 1'b0, '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, TimeMax, '0, 1'b1, hgw_pkg::CLS_HEALTHY, 1'b0, '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd5, 63'd10, 1'b1, hgw_pkg::CLS_HEALTHY, 1'b0,
            '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd500000001, 63'd1, 1'b1, hgw_pkg::CLS_SUSPECT, 1'b0,
            63'd500000000, 1, 0);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd500000000, 63'd1, 1'b1, hgw_pkg::CLS_HEALTHY, 1'b0,
            63'd500000000, 1, 0);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd2000000001, 63'd1, 1'b1, hgw_pkg::CLS_DEAD, 1'b0,
            63'd2000000000, 1, 1);
    add_row(hgw_pkg::ACT_TAKE, '0, '0, 1'b1, hgw_pkg::CLS_DEAD, 1'b1,
            63'd2000000000, 1, 1);
    add_row(hgw_pkg::ACT_TAKE, TimeMax, TimeMax, 1'b1, hgw_pkg::CLS_DEAD, 1'b0,
            63'd2000000000, 1, 1);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd2000000000, 63'd1, 1'b1, hgw_pkg::CLS_SUSPECT, 1'b0,
            63'd2000000000, 2, 1);
    add_row(hgw_pkg::ACT_OBSERVE, TimeMax, 63'd1, 1'b1, hgw_pkg::CLS_DEAD, 1'b0,
            TimeMax - 1'b1, 2, 2);
    add_row(hgw_pkg::ACT_OBSERVE, TimeMax, TimeMax - 63'd500000000, 1'b0,
            hgw_pkg::CLS_HEALTHY, 1'b0, '0, 0, 0);
    add_row(hgw_pkg::ACT_TAKE, '0, '0, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0, '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd3000000007, 63'd7, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0,
            '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, '0, '0, 1'b1, hgw_pkg::CLS_HEALTHY, 1'b0,
            TimeMax - 1'b1, 3, 3);
    add_row(hgw_pkg::ACT_TAKE, '0, '0, 1'b1, hgw_pkg::CLS_HEALTHY, 1'b1,
            TimeMax - 1'b1, 3, 3);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd2000000005, 63'd5, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0,
            '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, 63'd400000009, 63'd9, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0,
            '0, 0, 0);
    add_row(hgw_pkg::ACT_TAKE, '0, '0, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0, '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, TimeMax, TimeMax, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0,
            '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, '0, TimeMax, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0, '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, TimeMax, 63'd1, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0,
            '0, 0, 0);
    add_row(hgw_pkg::ACT_OBSERVE, TimeMax - 63'd7, 63'd3, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0,
            '0, 0, 0);
    add_row(hgw_pkg::ACT_TAKE, '0, '0, 1'b0, hgw_pkg::CLS_HEALTHY, 1'b0, '0, 0, 0);

    phase_suspect = '{20'd500, 20'd0, 20'hFFFFF, 20'd3000, 20'd1, 20'd0};
    phase_dead    = '{20'd2000, 20'd0, 20'hFFFFF, 20'd100, 20'd2, 20'd0};
    phase_suspect[NumPhases-1] = ThrW'($urandom_range(1000000));
    phase_dead[NumPhases-1]    = ThrW'($urandom_range(1000000));

    tx_idle_pct = 22;
    rx_idle_pct = 74;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      offer_word(directed_rows[i].word, directed_rows[i].typed, directed_rows[i].result);
    wait_idle();

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph < 2) begin
        tx_idle_pct = 22;
        rx_idle_pct = 74;
      end else if (ph < 4) begin
        tx_idle_pct = 74;
        rx_idle_pct = 22;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      set_thresholds(phase_suspect[ph], phase_dead[ph]);
      for (int i = 0; i < PhaseWords; i++) begin
        if (ph == 1 && i == 20) hold_request = 1'b1;
        if (ph == 4 && i == PhaseWords / 2) wait_idle();
        offer_word(make_word(), 1'b0, '0);
      end
      wait_idle();
    end

    $display("Checked %0d result words from %0d input words over %0d threshold settings.",
             results_seen, words_sent, NumPhases + 1);
    $display("Predicted %0d suspect and %0d dead entries, largest gap %0d ns.",
             suspect_cnt, dead_cnt, widest_gap);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
